// File: design/chrt_pkg.sv
// chrt_pkg: shared sizes, codes and types for the chained hash risk table
// used by chrt_ctrl, chrt_dp, chained_hash_risk_table and chrt_checker
// no dependencies
package chrt_pkg;

	localparam int BUCKET_COUNT = 4096;
	localparam int POOL_SIZE    = 2048;
	localparam int KEY_BYTES    = 7;

	localparam int KEY_W    = 56;
	localparam int RISK_W   = 16;
	localparam int STATUS_W = 2;
	localparam int HASH_W   = 32;

	localparam int BKT_W  = $clog2(BUCKET_COUNT);
	localparam int IDX_W  = $clog2(POOL_SIZE);
	localparam int CNT_W  = $clog2(POOL_SIZE + 1);
	localparam int BYTE_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	localparam logic [HASH_W-1:0] HASH_SEED        = 32'd5381;
	localparam logic [RISK_W-1:0] DEFAULT_RISK_RST = 16'd16384;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT  = 2'd0,
		ST_MISS = 2'd1,
		ST_INS  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_HEAD,
		S_DECIDE,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} head_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [RISK_W-1:0] risk;
		logic              next_valid;
		logic [IDX_W-1:0]  next;
	} entry_t;

	typedef struct packed {
		logic    clr_wr;
		logic    capture;
		logic    hash_step;
		logic    head_rd;
		logic    ins_wr;
		logic    walk_head;
		logic    walk_next;
		logic    res_set;
		status_t res_status;
		logic    res_ld;
	} ctrl_t;

	typedef struct packed {
		logic clr_last;
		logic hash_last;
		logic is_lookup;
		logic pool_full;
		logic head_valid;
		logic key_match;
		logic next_valid;
	} stat_t;

endpackage

// File: design/chained_hash_risk_table.sv
// Chained hash table from short text keys (up to 7 bytes, ended by the first zero byte)
// to a 16-bit risk value. After reset the 4096 bucket heads are cleared in one pass,
// during which in_stall stays high; default_risk writes are taken at any time. One
// item is worked at a time: an insert hashes the key, reads the bucket head and
// writes the entry when the pool has room; a lookup hashes, reads the head and walks
// the chain. The time taken is set by the byte-per-cycle hash and by the single read
// port of the entry memory, which fetches one chain link per cycle. A finished result sits in an
// output register, so the block takes the next beat while that result waits.
module chained_hash_risk_table import chrt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [KEY_W-1:0]    key_text,
	input  logic [RISK_W-1:0]   risk_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [RISK_W-1:0]   risk_out,
	input  logic                cfg_we,
	input  logic [RISK_W-1:0]   cfg_data
);

	ctrl_t ctrl;
	stat_t stat;

	chrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	chrt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.cmd      (cmd),
		.key_text (key_text),
		.risk_in  (risk_in),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.status   (status),
		.risk_out (risk_out)
	);

endmodule

// File: design/chrt_ctrl.sv
// chrt_ctrl: sequencer for clearing, hashing, chain walk and result hand-off
// depends on chrt_pkg; drives chrt_dp through ctrl_t, reads stat_t
module chrt_ctrl import chrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q, state_nx;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctrl.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		ctrl     = '0;
		ctrl.res_status = ST_MISS;
		case (state_q)
			S_CLEAR: begin
				ctrl.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					ctrl.capture = 1'b1;
					state_nx     = S_HASH;
				end
			end
			S_HASH: begin
				ctrl.hash_step = 1'b1;
				if (stat.hash_last) begin
					state_nx = S_HEAD;
				end
			end
			S_HEAD: begin
				ctrl.head_rd = 1'b1;
				state_nx     = S_DECIDE;
			end
			S_DECIDE: begin
				if (!stat.is_lookup) begin
					ctrl.res_set = 1'b1;
					state_nx     = S_DONE;
					if (stat.pool_full) begin
						ctrl.res_status = ST_FULL;
					end else begin
						ctrl.ins_wr     = 1'b1;
						ctrl.res_status = ST_INS;
					end
				end else if (stat.head_valid) begin
					ctrl.walk_head = 1'b1;
					state_nx       = S_WALK;
				end else begin
					ctrl.res_set    = 1'b1;
					ctrl.res_status = ST_MISS;
					state_nx        = S_DONE;
				end
			end
			S_WALK: begin
				if (stat.key_match) begin
					ctrl.res_set    = 1'b1;
					ctrl.res_status = ST_HIT;
					state_nx        = S_DONE;
				end else if (stat.next_valid) begin
					ctrl.walk_next = 1'b1;
				end else begin
					ctrl.res_set    = 1'b1;
					ctrl.res_status = ST_MISS;
					state_nx        = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ctrl.res_ld = 1'b1;
					state_nx    = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: design/chrt_dp.sv
// chrt_dp: key normalizing, byte-serial hash, bucket head and entry memories
// depends on chrt_pkg; commanded by chrt_ctrl through ctrl_t
module chrt_dp import chrt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	output stat_t               stat,
	input  logic                cmd,
	input  logic [KEY_W-1:0]    key_text,
	input  logic [RISK_W-1:0]   risk_in,
	input  logic                cfg_we,
	input  logic [RISK_W-1:0]   cfg_data,
	output logic [STATUS_W-1:0] status,
	output logic [RISK_W-1:0]   risk_out
);

	head_t  bucket_mem [BUCKET_COUNT];
	entry_t entry_mem  [POOL_SIZE];

	logic [BKT_W-1:0]    clr_cnt_q;
	logic [BYTE_W-1:0]   byte_cnt_q;
	logic [CNT_W-1:0]    pool_used_q;
	logic [RISK_W-1:0]   default_risk_q;

	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [RISK_W-1:0]   risk_q;
	logic [HASH_W-1:0]   hash_q;
	head_t               head_rd_q;
	entry_t              entry_rd_q;
	status_t             res_status_q;
	logic [RISK_W-1:0]   res_risk_q;
	logic [STATUS_W-1:0] status_q;
	logic [RISK_W-1:0]   risk_out_q;

	logic [KEY_W-1:0]  key_norm;
	logic [7:0]        hash_byte;
	logic [BKT_W-1:0]  bucket;
	logic              bkt_we;
	logic [BKT_W-1:0]  bkt_waddr;
	head_t             bkt_wdata;
	logic [IDX_W-1:0]  ent_raddr;
	entry_t            ent_wdata;
	logic [RISK_W-1:0] res_risk_nx;

	// key ends at the first zero byte
	always_comb begin
		logic alive;
		alive    = 1'b1;
		key_norm = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			alive = alive && (key_text[8*i +: 8] != 8'h00);
			if (alive) begin
				key_norm[8*i +: 8] = key_text[8*i +: 8];
			end
		end
	end

	assign hash_byte = key_q[{byte_cnt_q, 3'b000} +: 8];
	assign bucket    = BKT_W'(hash_q % BUCKET_COUNT);

	assign bkt_we    = ctrl.clr_wr | ctrl.ins_wr;
	assign bkt_waddr = ctrl.clr_wr ? clr_cnt_q : bucket;
	always_comb begin
		bkt_wdata = '0;
		if (!ctrl.clr_wr) begin
			bkt_wdata.valid = 1'b1;
			bkt_wdata.idx   = pool_used_q[IDX_W-1:0];
		end
	end

	assign ent_raddr = ctrl.walk_head ? head_rd_q.idx : entry_rd_q.next;
	always_comb begin
		ent_wdata.key        = key_q;
		ent_wdata.risk       = risk_q;
		ent_wdata.next_valid = head_rd_q.valid;
		ent_wdata.next       = head_rd_q.idx;
	end

	always_ff @(posedge clk) begin
		if (bkt_we) begin
			bucket_mem[bkt_waddr] <= bkt_wdata;
		end
		if (ctrl.head_rd) begin
			head_rd_q <= bucket_mem[bucket];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins_wr) begin
			entry_mem[pool_used_q[IDX_W-1:0]] <= ent_wdata;
		end
		if (ctrl.walk_head || ctrl.walk_next) begin
			entry_rd_q <= entry_mem[ent_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q      <= '0;
			byte_cnt_q     <= '0;
			pool_used_q    <= '0;
			default_risk_q <= DEFAULT_RISK_RST;
		end else begin
			if (ctrl.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (ctrl.capture) begin
				byte_cnt_q <= '0;
			end else if (ctrl.hash_step) begin
				byte_cnt_q <= byte_cnt_q + 1'b1;
			end
			if (ctrl.ins_wr) begin
				pool_used_q <= pool_used_q + 1'b1;
			end
			if (cfg_we) begin
				default_risk_q <= cfg_data;
			end
		end
	end

	always_comb begin
		case (res_status_q)
			ST_HIT:  res_risk_nx = entry_rd_q.risk;
			ST_MISS: res_risk_nx = default_risk_q;
			default: res_risk_nx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q  <= cmd_t'(cmd);
			key_q  <= key_norm;
			risk_q <= risk_in;
			hash_q <= HASH_SEED;
		end else if (ctrl.hash_step && (hash_byte != 8'h00)) begin
			hash_q <= ((hash_q << 5) + hash_q) ^ {{(HASH_W-8){1'b0}}, hash_byte};
		end
		if (ctrl.res_set) begin
			res_status_q <= ctrl.res_status;
		end
		if (ctrl.res_ld) begin
			status_q   <= res_status_q;
			risk_out_q <= res_risk_nx;
		end
	end

	always_comb begin
		stat.clr_last   = (clr_cnt_q == BKT_W'(BUCKET_COUNT - 1));
		stat.hash_last  = (byte_cnt_q == BYTE_W'(KEY_BYTES - 1));
		stat.is_lookup  = (cmd_q == CMD_LOOKUP);
		stat.pool_full  = (pool_used_q == CNT_W'(POOL_SIZE));
		stat.head_valid = head_rd_q.valid;
		stat.key_match  = (entry_rd_q.key == key_q);
		stat.next_valid = entry_rd_q.next_valid;
	end

	assign status   = status_q;
	assign risk_out = risk_out_q;

endmodule

// File: design/chrt_checker.sv
// chrt_checker: port-level checks of the chained hash risk table
// depends on chrt_pkg; bound to chained_hash_risk_table
module chrt_checker import chrt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [RISK_W-1:0]   risk_out
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(risk_out))
		else $error("stalled result beat changed");

	// insert outcomes carry zero risk
	a_ins_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_INS || status == ST_FULL) |-> risk_out == '0)
		else $error("insert result with nonzero risk");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("beat accepted while busy");

	// no result appears right after an accept made while the output is empty
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result before work done");

endmodule

bind chained_hash_risk_table chrt_checker u_chk (.*);
